// ----- src/chg_pkg.sv -----
`timescale 1ns / 1ps

package chg_pkg;

	// default geometry of the block
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;

	// result of one orientation test, handed from the cross unit to the sequencer
	typedef struct packed {
		logic done;   // one-cycle pulse, fields below valid with it
		logic gt;     // cross product strictly positive
		logic eq;     // cross product zero
		logic near;   // first point closer to the origin point than the second
	} cross_res_t;

endpackage

// ----- src/chg_ifs.sv -----
`timescale 1ns / 1ps

interface pt_if import chg_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CB-1:0] pt_x;
	logic signed [CB-1:0] pt_y;
	logic                 set_end;

	modport source(output valid, pt_x, pt_y, set_end, input ready);
	modport sink(input valid, pt_x, pt_y, set_end, output ready);
endinterface

interface hull_if import chg_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int SW = $clog2(MAX_POINTS_DEF + 1)
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CB-1:0] hull_x;
	logic signed [CB-1:0] hull_y;
	logic [SW-1:0]        hull_size;
	logic                 hull_last;

	modport source(output valid, hull_x, hull_y, hull_size, hull_last, input ready);
	modport sink(input valid, hull_x, hull_y, hull_size, hull_last, output ready);
endinterface

// ----- src/chg_cross.sv -----
`timescale 1ns / 1ps

// Orientation test (a - o) x (b - o) with one shared multiplier.
// Start latches the differences; stg_q then steps through the two products and the compare before done.
module chg_cross import chg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] o_x,
	input  logic signed [COORD_BITS-1:0] o_y,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	output cross_res_t                   res
);
	localparam int DW = COORD_BITS + 1;
	localparam int MW = 2 * DW;

	logic signed [DW-1:0] ax, ay, bx, by;
	logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
	logic [DW-1:0]        mag_ax, mag_ay, mag_bx, mag_by;
	logic [DW:0]          da_q, db_q;
	logic [2:0]           stg_q;
	logic signed [DW-1:0] m_a, m_b;
	logic signed [MW-1:0] prod, p_q, q_q;
	logic                 done_q, gt_q, eq_q, near_q;

	// differences to the origin point, one bit wider than the coordinates
	assign ax = $signed({a_x[COORD_BITS-1], a_x}) - $signed({o_x[COORD_BITS-1], o_x});
	assign ay = $signed({a_y[COORD_BITS-1], a_y}) - $signed({o_y[COORD_BITS-1], o_y});
	assign bx = $signed({b_x[COORD_BITS-1], b_x}) - $signed({o_x[COORD_BITS-1], o_x});
	assign by = $signed({b_y[COORD_BITS-1], b_y}) - $signed({o_y[COORD_BITS-1], o_y});

	assign mag_ax = ax[DW-1] ? DW'(-ax) : DW'(ax);
	assign mag_ay = ay[DW-1] ? DW'(-ay) : DW'(ay);
	assign mag_bx = bx[DW-1] ? DW'(-bx) : DW'(bx);
	assign mag_by = by[DW-1] ? DW'(-by) : DW'(by);

	// one multiplier: ax*by in the first step, bx*ay in the second
	assign m_a  = stg_q[0] ? ax_q : bx_q;
	assign m_b  = stg_q[0] ? by_q : ay_q;
	assign prod = MW'(m_a) * MW'(m_b);

	// latch operands and sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q  <= '0;
			done_q <= 1'b0;
		end else begin
			stg_q  <= {stg_q[1:0], start};
			done_q <= stg_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ax_q <= ax;
			ay_q <= ay;
			bx_q <= bx;
			by_q <= by;
			da_q <= {1'b0, mag_ax} + {1'b0, mag_ay};
			db_q <= {1'b0, mag_bx} + {1'b0, mag_by};
		end
		if (stg_q[0]) p_q <= prod;
		if (stg_q[1]) q_q <= prod;
		// compare the two products
		if (stg_q[2]) begin
			gt_q   <= p_q > q_q;
			eq_q   <= p_q == q_q;
			near_q <= da_q < db_q;
		end
	end

	assign res = '{done: done_q, gt: gt_q, eq: eq_q, near: near_q};
endmodule

// ----- src/convex_hull_graham.sv -----
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                   | Handshake
// pt_in     | in  | pt_x, pt_y, set_end                        | valid/ready
// hull_out  | out | hull_x, hull_y, hull_size, hull_last       | valid/ready
//
// A point without end mark is stored, up to MAX_POINTS, and loading goes on.
// An end mark starts the hull run: a pivot swap, a selection sort with
// (n-1)(n-2)/2 cross tests, a stack scan, and the emission of each vertex,
// which waits on hull_out.ready; a set under three points goes straight to
// emission. The shared cross unit sets the pace.
// pt_in.ready is low from the end mark until the last vertex is taken.
// arst_n clears the sequencer and point count; point and stack memories are not cleared.
module convex_hull_graham import chg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	pt_if.sink      pt_in,
	hull_if.source  hull_out
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = 2 * COORD_BITS;

	typedef enum logic [20:0] {
		ST_LOAD = 21'd1 << 0,
		ST_PRD  = 21'd1 << 1,
		ST_PW1  = 21'd1 << 2,
		ST_PW2  = 21'd1 << 3,
		ST_SI   = 21'd1 << 4,
		ST_SB   = 21'd1 << 5,
		ST_SJ   = 21'd1 << 6,
		ST_SW   = 21'd1 << 7,
		ST_SX1  = 21'd1 << 8,
		ST_SX2  = 21'd1 << 9,
		ST_SX3  = 21'd1 << 10,
		ST_GI   = 21'd1 << 11,
		ST_GB   = 21'd1 << 12,
		ST_GC   = 21'd1 << 13,
		ST_GW   = 21'd1 << 14,
		ST_GP1  = 21'd1 << 15,
		ST_GP2  = 21'd1 << 16,
		ST_ER   = 21'd1 << 17,
		ST_ES   = 21'd1 << 18,
		ST_EO   = 21'd1 << 19,
		ST_EW   = 21'd1 << 20
	} state_t;

	state_t state_q;

	logic [PW-1:0] pmem [MAX_POINTS];
	logic [AW-1:0] smem [MAX_POINTS];
	logic [PW-1:0] prd_q;
	logic [AW-1:0] srd_q;

	logic [AW-1:0] p_ra, p_wa, s_ra, s_wa;
	logic [PW-1:0] p_wd;
	logic [AW-1:0] s_wd;
	logic          p_we, s_we;

	logic [CW-1:0] cnt_q, n_q, n_next;
	logic [AW-1:0] pidx_q, i_q, j_q, k_q, top_q, e_q;
	logic [PW-1:0] pvt_q, best_q, cand_q, pa_q, pb_q, pc_q;
	logic          small_q;

	logic          acc, store_ok, better, out_take;
	logic signed [COORD_BITS-1:0] in_x, in_y, pvt_x, pvt_y;

	logic          cx_start;
	logic [PW-1:0] cx_o, cx_a, cx_b;
	cross_res_t    cx_res;
	logic          pick, emit_last;

	logic                 ovalid_q;
	logic [PW-1:0]        opt_q;
	logic [CW-1:0]        osize_q;
	logic                 olast_q;

	assign in_x  = pt_in.pt_x;
	assign in_y  = pt_in.pt_y;
	assign pvt_x = $signed(pvt_q[PW-1:COORD_BITS]);
	assign pvt_y = $signed(pvt_q[COORD_BITS-1:0]);

	assign pt_in.ready = (state_q == ST_LOAD);
	assign acc         = pt_in.valid & pt_in.ready;
	assign out_take    = hull_out.valid & hull_out.ready;
	assign store_ok    = cnt_q < CW'(MAX_POINTS);
	assign better      = (cnt_q == '0) || (in_y < pvt_y) || ((in_y == pvt_y) && (in_x < pvt_x));
	assign n_next      = store_ok ? cnt_q + CW'(1) : cnt_q;
	assign pick        = cx_res.gt | (cx_res.eq & cx_res.near);
	assign emit_last   = small_q ? (CW'(e_q) + CW'(1) == n_q) : (e_q == top_q);

	// point store and stack memories, registered reads
	always_ff @(posedge clk) begin
		if (p_we) pmem[p_wa] <= p_wd;
		prd_q <= pmem[p_ra];
		if (s_we) smem[s_wa] <= s_wd;
		srd_q <= smem[s_ra];
	end

	// memory addresses and cross unit operands per state
	always_comb begin
		p_ra     = '0;
		p_we     = 1'b0;
		p_wa     = '0;
		p_wd     = prd_q;
		s_ra     = '0;
		s_we     = 1'b0;
		s_wa     = '0;
		s_wd     = i_q;
		cx_start = 1'b0;
		cx_o     = pvt_q;
		cx_a     = prd_q;
		cx_b     = best_q;
		unique case (state_q)
			ST_LOAD: begin
				p_we = acc & store_ok;
				p_wa = cnt_q[AW-1:0];
				p_wd = {pt_in.pt_x, pt_in.pt_y};
			end
			ST_PRD: p_ra = '0;
			ST_PW1: begin
				p_we = 1'b1;
				p_wa = pidx_q;
				p_wd = prd_q;
			end
			ST_PW2: begin
				p_we = 1'b1;
				p_wa = '0;
				p_wd = pvt_q;
			end
			ST_SI: p_ra = i_q;
			ST_SB: p_ra = i_q + AW'(1);
			ST_SJ: cx_start = 1'b1;
			ST_SW: p_ra = j_q + AW'(1);
			ST_SX1: p_ra = i_q;
			ST_SX2: begin
				p_we = 1'b1;
				p_wa = k_q;
				p_wd = prd_q;
			end
			ST_SX3: begin
				p_we = 1'b1;
				p_wa = i_q;
				p_wd = best_q;
			end
			ST_GI: begin
				p_ra = AW'(1);
				s_we = 1'b1;
				s_wa = '0;
				s_wd = '0;
			end
			ST_GB: begin
				p_ra = AW'(2);
				s_we = 1'b1;
				s_wa = AW'(1);
				s_wd = AW'(1);
			end
			ST_GC: begin
				cx_start = 1'b1;
				cx_o     = pa_q;
				cx_a     = pb_q;
				cx_b     = prd_q;
			end
			ST_GW: begin
				p_ra = i_q + AW'(1);
				s_ra = top_q - AW'(2);
				if (cx_res.done && (cx_res.gt || top_q == AW'(1))) begin
					s_we = 1'b1;
					s_wa = cx_res.gt ? top_q + AW'(1) : AW'(1);
					s_wd = i_q;
				end
			end
			ST_GP1: p_ra = srd_q;
			ST_GP2: begin
				cx_start = 1'b1;
				cx_o     = prd_q;
				cx_a     = pb_q;
				cx_b     = pc_q;
			end
			ST_ER: begin
				p_ra = e_q;
				s_ra = e_q;
			end
			ST_ES: p_ra = srd_q;
			ST_EO: p_ra = srd_q;
			ST_EW: p_ra = srd_q;
			default: p_ra = '0;
		endcase
	end

	chg_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cx_start),
		.o_x   ($signed(cx_o[PW-1:COORD_BITS])),
		.o_y   ($signed(cx_o[COORD_BITS-1:0])),
		.a_x   ($signed(cx_a[PW-1:COORD_BITS])),
		.a_y   ($signed(cx_a[COORD_BITS-1:0])),
		.b_x   ($signed(cx_b[PW-1:COORD_BITS])),
		.b_y   ($signed(cx_b[COORD_BITS-1:0])),
		.res   (cx_res)
	);

	// sequencer: load, pivot swap, sort, stack scan, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						cnt_q <= n_next;
						if (pt_in.set_end) begin
							cnt_q <= '0;
							if (n_next < CW'(3)) state_q <= ST_ER;
							else                 state_q <= ST_PRD;
						end
					end
				end
				ST_PRD: state_q <= ST_PW1;
				ST_PW1: state_q <= ST_PW2;
				ST_PW2: state_q <= ST_SI;
				ST_SI:  state_q <= ST_SB;
				ST_SB:  state_q <= ST_SJ;
				ST_SJ:  state_q <= ST_SW;
				ST_SW: begin
					if (cx_res.done) begin
						if (CW'(j_q) + CW'(1) == n_q) state_q <= ST_SX1;
						else                          state_q <= ST_SJ;
					end
				end
				ST_SX1: state_q <= ST_SX2;
				ST_SX2: state_q <= ST_SX3;
				ST_SX3: begin
					if (CW'(i_q) + CW'(2) < n_q) state_q <= ST_SI;
					else                         state_q <= ST_GI;
				end
				ST_GI: state_q <= ST_GB;
				ST_GB: state_q <= ST_GC;
				ST_GC: state_q <= ST_GW;
				ST_GW: begin
					if (cx_res.done) begin
						if (!cx_res.gt && top_q != AW'(1)) state_q <= ST_GP1;
						else if (CW'(i_q) + CW'(1) < n_q)  state_q <= ST_GC;
						else                               state_q <= ST_ER;
					end
				end
				ST_GP1: state_q <= ST_GP2;
				ST_GP2: state_q <= ST_GW;
				ST_ER: begin
					if (small_q) state_q <= ST_EO;
					else         state_q <= ST_ES;
				end
				ST_ES: state_q <= ST_EO;
				ST_EO: begin
					ovalid_q <= 1'b1;
					state_q  <= ST_EW;
				end
				ST_EW: begin
					if (out_take) begin
						ovalid_q <= 1'b0;
						if (olast_q) state_q <= ST_LOAD;
						else         state_q <= ST_ER;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// working registers of the run
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (acc && store_ok && better) begin
					pvt_q  <= {pt_in.pt_x, pt_in.pt_y};
					pidx_q <= cnt_q[AW-1:0];
				end
				if (acc && pt_in.set_end) begin
					n_q     <= n_next;
					small_q <= n_next < CW'(3);
					e_q     <= '0;
				end
				i_q <= AW'(1);
			end
			ST_SB: begin
				best_q <= prd_q;
				k_q    <= i_q;
				j_q    <= i_q + AW'(1);
			end
			ST_SJ: cand_q <= prd_q;
			ST_SW: begin
				if (cx_res.done) begin
					if (pick) begin
						best_q <= cand_q;
						k_q    <= j_q;
					end
					j_q <= j_q + AW'(1);
				end
			end
			ST_SX3: i_q <= i_q + AW'(1);
			ST_GB: begin
				pa_q  <= pvt_q;
				pb_q  <= prd_q;
				top_q <= AW'(1);
				i_q   <= AW'(2);
			end
			ST_GC: pc_q <= prd_q;
			ST_GW: begin
				if (cx_res.done) begin
					if (!cx_res.gt && top_q != AW'(1)) begin
						// pop: old second entry becomes the top
						top_q <= top_q - AW'(1);
						pb_q  <= pa_q;
					end else begin
						if (cx_res.gt) begin
							top_q <= top_q + AW'(1);
							pa_q  <= pb_q;
						end
						// push the current point
						pb_q <= pc_q;
						i_q  <= i_q + AW'(1);
						e_q  <= '0;
					end
				end
			end
			ST_GP2: pa_q <= prd_q;
			ST_EO: begin
				opt_q   <= prd_q;
				osize_q <= small_q ? n_q : CW'(top_q) + CW'(1);
				olast_q <= emit_last;
			end
			ST_EW: begin
				if (out_take) e_q <= e_q + AW'(1);
			end
			default: e_q <= e_q;
		endcase
	end

	assign hull_out.valid     = ovalid_q;
	assign hull_out.hull_x    = $signed(opt_q[PW-1:COORD_BITS]);
	assign hull_out.hull_y    = $signed(opt_q[COORD_BITS-1:0]);
	assign hull_out.hull_size = osize_q;
	assign hull_out.hull_last = olast_q;
endmodule

// ----- src/chg_check.sv -----
`timescale 1ns / 1ps

module chg_check import chg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               in_end,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               out_last,
	input logic [$clog2(MAX_POINTS + 1)-1:0]  out_size
);
	// a waiting item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("hull item withdrawn before taken");

	// never loading and emitting at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a hull item is offered");

	// a point without end mark keeps the block loading
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_end |=> in_ready)
		else $error("block left loading without end mark");

	// more vertices follow a vertex that is not the last
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !in_ready)
		else $error("input reopened before the last vertex");

	// every vertex carries a nonzero count
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_size != '0)
		else $error("hull item with zero size");
endmodule

bind convex_hull_graham chg_check #(.MAX_POINTS(MAX_POINTS)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pt_in.valid),
	.in_ready (pt_in.ready),
	.in_end   (pt_in.set_end),
	.out_valid(hull_out.valid),
	.out_ready(hull_out.ready),
	.out_last (hull_out.hull_last),
	.out_size (hull_out.hull_size)
);
